@@ sv/amc_pkg.sv @@
// ----------------------------------------------------------------------------
// amc_pkg: shared types and constants for the address multiplexer controls
// Address windows, control location indexes, reset values and the structs
// passed between the decoder, the state block and the top level.
// ----------------------------------------------------------------------------
package amc_pkg;

  localparam int unsigned AddrW = 16;
  localparam int unsigned DataW = 8;
  localparam int unsigned CountW = 32;

  localparam logic [AddrW-1:0] VECTOR_BASE = 16'hFFF0;
  localparam logic [AddrW-1:0] CTRL_BASE   = 16'hFFC0;
  localparam logic [AddrW-1:0] CTRL_LAST   = 16'hFFDF;
  localparam logic [AddrW-1:0] ROM_MASK    = 16'hBFFF;

  // Control location index = low five address bits
  localparam logic [4:0] REG_MODE_FIRST   = 5'h00;
  localparam logic [4:0] REG_MODE_LAST    = 5'h05;
  localparam logic [4:0] REG_OFFSET_FIRST = 5'h06;
  localparam logic [4:0] REG_OFFSET_LAST  = 5'h13;
  localparam logic [4:0] REG_PAGE0        = 5'h14;
  localparam logic [4:0] REG_PAGE1        = 5'h15;
  localparam logic [4:0] REG_RATE_FIRST   = 5'h16;
  localparam logic [4:0] REG_RATE_LAST    = 5'h19;
  localparam logic [4:0] REG_ROM_MAP      = 5'h1E;
  localparam logic [4:0] REG_RAM_MAP      = 5'h1F;

  // Bit index of the first location pair of each field
  localparam logic [3:0] OFFSET_BIT0 = 4'd3;
  localparam logic [3:0] RATE_BIT0   = 4'd11;

  localparam logic [2:0] MODE_RST   = 3'd0;
  localparam logic [6:0] OFFSET_RST = 7'd2;
  localparam logic [1:0] RATE_RST   = 2'd0;

  // All-RAM selection counter increment
  localparam logic [CountW-1:0] COUNT_STEP = 32'd1;

  localparam logic REQ_WRITE = 1'b1;

  typedef struct packed {
    logic       hit;
    logic       redirect;
    logic       echo;       // write to a control location
    logic       mode_we;
    logic       offset_we;
    logic       rate_we;
    logic       page_clr;
    logic       page_set;
    logic       rom_sel;
    logic       ram_sel;
    logic       set_val;    // odd address sets, even clears
    logic [2:0] bit_idx;    // bit within the addressed field
  } amc_ctl_t;

  typedef struct packed {
    logic [2:0]        mode;
    logic [6:0]        offset;
    logic [1:0]        rate;
    logic              rom_map;
    logic              page;
    logic              remap;
    logic [CountW-1:0] ram_count;
  } amc_state_t;

endpackage

@@ sv/amc_decode.sv @@
// ----------------------------------------------------------------------------
// amc_decode: bus access decoder
// Classifies one access and turns a control location write into a set of
// update strobes with the targeted bit.
// ----------------------------------------------------------------------------
module amc_decode (
  input  logic                        req_type_i,
  input  logic [amc_pkg::AddrW-1:0]   address_i,
  output amc_pkg::amc_ctl_t           ctl_o
);

  logic [4:0] reg_idx;
  logic [3:0] pair_idx;
  logic [3:0] offset_pos;
  logic [3:0] rate_pos;
  logic       in_ctrl;

  assign reg_idx    = address_i[4:0];
  assign pair_idx   = reg_idx[4:1];
  assign offset_pos = pair_idx - amc_pkg::OFFSET_BIT0;
  assign rate_pos   = pair_idx - amc_pkg::RATE_BIT0;
  assign in_ctrl    = (address_i >= amc_pkg::CTRL_BASE) && (address_i <= amc_pkg::CTRL_LAST);

  always_comb begin
    ctl_o          = '0;
    ctl_o.set_val  = reg_idx[0];
    if (address_i >= amc_pkg::VECTOR_BASE) begin
      ctl_o.hit      = 1'b1;
      ctl_o.redirect = 1'b1;
    end else if (in_ctrl) begin
      ctl_o.hit = 1'b1;
      if (req_type_i == amc_pkg::REQ_WRITE) begin
        ctl_o.echo = 1'b1;
        case (reg_idx) inside
          [amc_pkg::REG_MODE_FIRST:amc_pkg::REG_MODE_LAST]: begin
            ctl_o.mode_we = 1'b1;
            ctl_o.bit_idx = {1'b0, reg_idx[2:1]};
          end
          [amc_pkg::REG_OFFSET_FIRST:amc_pkg::REG_OFFSET_LAST]: begin
            ctl_o.offset_we = 1'b1;
            ctl_o.bit_idx   = offset_pos[2:0];
          end
          amc_pkg::REG_PAGE0: ctl_o.page_clr = 1'b1;
          amc_pkg::REG_PAGE1: ctl_o.page_set = 1'b1;
          [amc_pkg::REG_RATE_FIRST:amc_pkg::REG_RATE_LAST]: begin
            ctl_o.rate_we = 1'b1;
            ctl_o.bit_idx = rate_pos[2:0];
          end
          amc_pkg::REG_ROM_MAP: ctl_o.rom_sel = 1'b1;
          amc_pkg::REG_RAM_MAP: ctl_o.ram_sel = 1'b1;
          default: ;  // memory size locations: no state change
        endcase
      end
    end
  end

endmodule

@@ sv/amc_state.sv @@
// ----------------------------------------------------------------------------
// amc_state: control state registers
// Applies decoded update strobes to the mode, offset, rate, map and page
// bits and the all-RAM selection counter; exposes the post-update value.
// ----------------------------------------------------------------------------
module amc_state (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  amc_pkg::amc_ctl_t   ctl_i,
  output amc_pkg::amc_state_t state_d_o
);

  amc_pkg::amc_state_t state_q;
  amc_pkg::amc_state_t state_d;

  always_comb begin
    state_d = state_q;
    if (ctl_i.mode_we) begin
      state_d.mode[ctl_i.bit_idx[1:0]] = ctl_i.set_val;
    end
    if (ctl_i.offset_we) begin
      state_d.offset[ctl_i.bit_idx] = ctl_i.set_val;
    end
    if (ctl_i.rate_we) begin
      state_d.rate[ctl_i.bit_idx[0]] = ctl_i.set_val;
    end
    if (ctl_i.page_clr) begin
      state_d.page  = 1'b0;
      state_d.remap = 1'b0;
    end
    if (ctl_i.page_set) begin
      state_d.page  = 1'b1;
      state_d.remap = state_q.rom_map;
    end
    if (ctl_i.rom_sel) begin
      state_d.rom_map = 1'b1;
      state_d.remap   = state_q.page;
    end
    if (ctl_i.ram_sel) begin
      state_d.rom_map   = 1'b0;
      state_d.remap     = 1'b0;
      state_d.ram_count = state_q.ram_count + amc_pkg::COUNT_STEP;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode      <= amc_pkg::MODE_RST;
      state_q.offset    <= amc_pkg::OFFSET_RST;
      state_q.rate      <= amc_pkg::RATE_RST;
      state_q.rom_map   <= 1'b1;
      state_q.page      <= 1'b0;
      state_q.remap     <= 1'b0;
      state_q.ram_count <= '0;
    end else if (en_i) begin
      state_q <= state_d;
    end
  end

  assign state_d_o = state_d;

endmodule

@@ sv/address_multiplexer_control_regs_unit.sv @@
// ----------------------------------------------------------------------------
// address_multiplexer_control_regs_unit: address multiplexer control registers
// Decodes CPU bus accesses against the write-only control locations and the
// vector area, updates the control bits and reports one result per access.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one bus access per beat:
//   req_type_i, address_i, write_data_i. Output channel (out_valid_o/
//   out_ready_i) returns exactly one result beat per input beat, in order,
//   with the decode, the echoed write byte and the control state after it.
//   Path: an accepted beat passes the input register, then decode/update
//   into the result register.
//   Throughput: one beat per cycle while unstalled (single decode-and-update).
//   Stall: when out_ready_i is low the result register holds, the input
//   register fills, and in_ready_o drops until the result is taken; state
//   updates only when a beat moves into the result register.
//   Reset: rst_ni (async, active low) empties both stages and restores
//   mode 0, offset 2, rate 0, ROM map, page 0, no remap, count 0.
// ----------------------------------------------------------------------------
module address_multiplexer_control_regs_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         req_type_i,
  input  logic [amc_pkg::AddrW-1:0]    address_i,
  input  logic [amc_pkg::DataW-1:0]    write_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         hit_o,
  output logic                         rom_redirect_o,
  output logic [amc_pkg::AddrW-1:0]    rom_address_o,
  output logic [amc_pkg::DataW-1:0]    read_value_o,
  output logic [2:0]                   video_mode_o,
  output logic [6:0]                   display_offset_o,
  output logic [1:0]                   cpu_rate_o,
  output logic                         rom_mapped_o,
  output logic                         page_select_o,
  output logic                         upper_to_lower_o,
  output logic [amc_pkg::CountW-1:0]   all_ram_count_o
);

  // Input stage
  logic                       in_valid_q;
  logic                       req_type_q;
  logic [amc_pkg::AddrW-1:0]  address_q;
  logic [amc_pkg::DataW-1:0]  write_data_q;

  // Result stage
  logic                       out_valid_q;
  logic                       hit_q;
  logic                       redirect_q;
  logic [amc_pkg::AddrW-1:0]  rom_address_q;
  logic [amc_pkg::DataW-1:0]  read_value_q;
  amc_pkg::amc_state_t        state_out_q;

  amc_pkg::amc_ctl_t          ctl;
  amc_pkg::amc_state_t        state_d;
  logic                       advance;
  logic                       in_fire;

  // Beat moves from input stage to result stage when the result slot is
  // free or being drained this cycle.
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_type_q   <= req_type_i;
      address_q    <= address_i;
      write_data_q <= write_data_i;
    end
  end

  amc_decode u_decode (
    .req_type_i (req_type_q),
    .address_i  (address_q),
    .ctl_o      (ctl)
  );

  // Control bits commit only on the advancing beat
  amc_state u_state (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (advance),
    .ctl_i     (ctl),
    .state_d_o (state_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      hit_q         <= ctl.hit;
      redirect_q    <= ctl.redirect;
      rom_address_q <= ctl.redirect ? (address_q & amc_pkg::ROM_MASK) : '0;
      read_value_q  <= ctl.echo ? write_data_q : '0;
      state_out_q   <= state_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign hit_o            = hit_q;
  assign rom_redirect_o   = redirect_q;
  assign rom_address_o    = rom_address_q;
  assign read_value_o     = read_value_q;
  assign video_mode_o     = state_out_q.mode;
  assign display_offset_o = state_out_q.offset;
  assign cpu_rate_o       = state_out_q.rate;
  assign rom_mapped_o     = state_out_q.rom_map;
  assign page_select_o    = state_out_q.page;
  assign upper_to_lower_o = state_out_q.remap;
  assign all_ram_count_o  = state_out_q.ram_count;

endmodule

@@ tb/tb_address_multiplexer_control_regs_unit.sv @@
// ----------------------------------------------------------------------------
// tb_address_multiplexer_control_regs_unit: self-checking bench for the
// address multiplexer control registers
// Sends directed and random bus accesses through the valid/ready input
// channel. Every accepted access runs through a local model of the control
// bits, which queues the result it should produce. Result beats are checked
// field by field, in order. Both sides idle in random bursts. There is one
// long receiver hold-off and one sender pause until the pipe is empty.
// ----------------------------------------------------------------------------
module tb_address_multiplexer_control_regs_unit;

  localparam logic REQ_READ    = ~amc_pkg::REQ_WRITE;
  localparam int   STALL_LIMIT = 1000;  // cycles with no beat on either side
  localparam int   HOLD_CYCLES = 60;    // long receiver hold-off
  localparam int   HOLD_AT     = 450;   // results seen before the hold-off
  localparam logic [amc_pkg::AddrW-1:0] ADDR_STEP = 16'd1;

  typedef struct packed {
    logic                      wr;
    logic [amc_pkg::AddrW-1:0] addr;
    logic [amc_pkg::DataW-1:0] data;
  } bus_access_t;

  typedef struct packed {
    logic                      hit;
    logic                      redirect;
    logic [amc_pkg::AddrW-1:0] rom_addr;
    logic [amc_pkg::DataW-1:0] rd_val;
    amc_pkg::amc_state_t       st;
  } access_result_t;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       in_valid_i;
  logic                       in_ready_o;
  logic                       req_type_i;
  logic [amc_pkg::AddrW-1:0]  address_i;
  logic [amc_pkg::DataW-1:0]  write_data_i;
  logic                       out_valid_o;
  logic                       out_ready_i;
  logic                       hit_o;
  logic                       rom_redirect_o;
  logic [amc_pkg::AddrW-1:0]  rom_address_o;
  logic [amc_pkg::DataW-1:0]  read_value_o;
  logic [2:0]                 video_mode_o;
  logic [6:0]                 display_offset_o;
  logic [1:0]                 cpu_rate_o;
  logic                       rom_mapped_o;
  logic                       page_select_o;
  logic                       upper_to_lower_o;
  logic [amc_pkg::CountW-1:0] all_ram_count_o;

  address_multiplexer_control_regs_unit DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .req_type_i       (req_type_i),
    .address_i        (address_i),
    .write_data_i     (write_data_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .hit_o            (hit_o),
    .rom_redirect_o   (rom_redirect_o),
    .rom_address_o    (rom_address_o),
    .read_value_o     (read_value_o),
    .video_mode_o     (video_mode_o),
    .display_offset_o (display_offset_o),
    .cpu_rate_o       (cpu_rate_o),
    .rom_mapped_o     (rom_mapped_o),
    .page_select_o    (page_select_o),
    .upper_to_lower_o (upper_to_lower_o),
    .all_ram_count_o  (all_ram_count_o)
  );

  bus_access_t         pending_q[$];   // accesses not yet accepted
  access_result_t      result_q[$];    // results owed by the block, oldest first
  amc_pkg::amc_state_t ctl_bits;       // model copy of the control state
  int                  errors;
  int                  results_seen;
  int                  stall_cycles;
  logic                in_sent;        // input beat taken at the last rising edge
  logic                calm;           // no idling on either side
  int                  in_idle;
  int                  out_idle;
  int                  hold_left;
  logic                hold_done;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Model of one access: decode, update the control bits, build the result.
  function automatic access_result_t apply_access(input bus_access_t a);
    access_result_t r;
    logic [4:0]     idx;
    logic [3:0]     bpos;
    logic [3:0]     fpos;
    logic           setv;
    r    = '0;
    idx  = a.addr[4:0];
    bpos = idx[4:1];
    setv = idx[0];
    if (a.addr >= amc_pkg::VECTOR_BASE) begin
      r.hit      = 1'b1;
      r.redirect = 1'b1;
      r.rom_addr = a.addr & amc_pkg::ROM_MASK;
    end else if (a.addr >= amc_pkg::CTRL_BASE && a.addr <= amc_pkg::CTRL_LAST) begin
      r.hit = 1'b1;
      if (a.wr == amc_pkg::REQ_WRITE) begin
        r.rd_val = a.data;
        if (idx <= amc_pkg::REG_MODE_LAST) begin
          ctl_bits.mode[bpos[1:0]] = setv;
        end else if (idx <= amc_pkg::REG_OFFSET_LAST) begin
          fpos = bpos - amc_pkg::OFFSET_BIT0;
          ctl_bits.offset[fpos[2:0]] = setv;
        end else if (idx == amc_pkg::REG_PAGE0) begin
          ctl_bits.page  = 1'b0;
          ctl_bits.remap = 1'b0;
        end else if (idx == amc_pkg::REG_PAGE1) begin
          ctl_bits.page  = 1'b1;
          ctl_bits.remap = ctl_bits.rom_map;
        end else if (idx <= amc_pkg::REG_RATE_LAST) begin
          fpos = bpos - amc_pkg::RATE_BIT0;
          ctl_bits.rate[fpos[0]] = setv;
        end else if (idx == amc_pkg::REG_ROM_MAP) begin
          ctl_bits.rom_map = 1'b1;
          ctl_bits.remap   = ctl_bits.page;
        end else if (idx == amc_pkg::REG_RAM_MAP) begin
          ctl_bits.rom_map   = 1'b0;
          ctl_bits.remap     = 1'b0;
          ctl_bits.ram_count = ctl_bits.ram_count + amc_pkg::COUNT_STEP;
        end
        // memory size locations: data echoed, no state change
      end
    end
    r.st = ctl_bits;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endtask

  function automatic logic [amc_pkg::AddrW-1:0] ctrl_addr(input logic [4:0] idx);
    return {amc_pkg::CTRL_BASE[amc_pkg::AddrW-1:5], idx};
  endfunction

  task automatic queue_access(input logic wr, input logic [amc_pkg::AddrW-1:0] addr,
                              input logic [amc_pkg::DataW-1:0] data);
    bus_access_t a;
    a.wr   = wr;
    a.addr = addr;
    a.data = data;
    pending_q.push_back(a);
  endtask

  // Random mix: mostly control writes, so the state gets deep coverage,
  // with reads, vector fetches, the unmapped hole and any address as noise.
  task automatic add_random(input int n);
    bus_access_t a;
    int          pick;
    for (int i = 0; i < n; i++) begin
      pick   = $urandom_range(0, 99);
      a.wr   = 1'($urandom_range(0, 1));
      a.addr = 16'($urandom_range(0, 65535));
      a.data = 8'($urandom_range(0, 255));
      if (pick < 55) begin
        a.wr = amc_pkg::REQ_WRITE;
        a.addr[amc_pkg::AddrW-1:5] = amc_pkg::CTRL_BASE[amc_pkg::AddrW-1:5];
      end else if (pick < 65) begin
        a.wr = REQ_READ;
        a.addr[amc_pkg::AddrW-1:5] = amc_pkg::CTRL_BASE[amc_pkg::AddrW-1:5];
      end else if (pick < 75) begin
        a.addr[amc_pkg::AddrW-1:4] = amc_pkg::VECTOR_BASE[amc_pkg::AddrW-1:4];
      end else if (pick < 85) begin
        a.addr[amc_pkg::AddrW-1:4] = amc_pkg::CTRL_LAST[amc_pkg::AddrW-1:4]
                                     + ADDR_STEP[amc_pkg::AddrW-5:0];
      end
      pending_q.push_back(a);
    end
  endtask

  // Sender: holds a beat until taken, otherwise idles in bursts or
  // presents the next pending access. Changes on the falling edge.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_sent) begin
        // beat still waiting for ready, keep it
      end else if (in_idle > 0) begin
        in_valid_i <= 1'b0;
        in_idle = in_idle - 1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        in_valid_i <= 1'b0;
        in_idle = $urandom_range(0, 10);
      end else if (pending_q.size() > 0) begin
        in_valid_i   <= 1'b1;
        req_type_i   <= pending_q[0].wr;
        address_i    <= pending_q[0].addr;
        write_data_i <= pending_q[0].data;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: random ready bursts, plus one long hold-off so the block
  // fills up and drops in_ready_o while the sender keeps offering.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left = hold_left - 1;
      end else if (!hold_done && results_seen >= HOLD_AT) begin
        out_ready_i <= 1'b0;
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
      end else if (out_idle > 0) begin
        out_ready_i <= 1'b0;
        out_idle = out_idle - 1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        out_ready_i <= 1'b0;
        out_idle = $urandom_range(0, 10);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Rising edge: take input beats into the model, check result beats,
  // and watch for a hung handshake.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_sent <= in_valid_i && in_ready_o;
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (result_q.size() == 0) begin
          $error("result beat with no access outstanding");
          errors++;
        end else begin
          access_result_t want;
          want = result_q.pop_front();
          check_field("hit", 32'(want.hit), 32'(hit_o));
          check_field("rom_redirect", 32'(want.redirect), 32'(rom_redirect_o));
          check_field("rom_address", 32'(want.rom_addr), 32'(rom_address_o));
          check_field("read_value", 32'(want.rd_val), 32'(read_value_o));
          check_field("video_mode", 32'(want.st.mode), 32'(video_mode_o));
          check_field("display_offset", 32'(want.st.offset), 32'(display_offset_o));
          check_field("cpu_rate", 32'(want.st.rate), 32'(cpu_rate_o));
          check_field("rom_mapped", 32'(want.st.rom_map), 32'(rom_mapped_o));
          check_field("page_select", 32'(want.st.page), 32'(page_select_o));
          check_field("upper_to_lower", 32'(want.st.remap), 32'(upper_to_lower_o));
          check_field("all_ram_count", want.st.ram_count, all_ram_count_o);
        end
      end
      if (in_valid_i && in_ready_o) begin
        result_q.push_back(apply_access(pending_q.pop_front()));
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("tb_address_multiplexer_control_regs_unit: done, errors");
          $finish;
        end
      end
    end
  end

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    req_type_i   = REQ_READ;
    address_i    = '0;
    write_data_i = '0;
    out_ready_i  = 1'b0;
    in_sent      = 1'b0;
    calm         = 1'b0;
    in_idle      = 0;
    out_idle     = 0;
    hold_left    = 0;
    hold_done    = 1'b0;
    errors       = 0;
    results_seen = 0;
    stall_cycles = 0;
    ctl_bits           = '0;
    ctl_bits.mode      = amc_pkg::MODE_RST;
    ctl_bits.offset    = amc_pkg::OFFSET_RST;
    ctl_bits.rate      = amc_pkg::RATE_RST;
    ctl_bits.rom_map   = 1'b1;

    // Directed part: reset state, each control group, map/page interplay,
    // memory size locations, vector area and unmapped addresses.
    queue_access(REQ_READ, ctrl_addr(amc_pkg::REG_RAM_MAP), 8'hFF); // read: no change
    queue_access(amc_pkg::REQ_WRITE, ctrl_addr(amc_pkg::REG_MODE_LAST), 8'hFF); // bit 2
    queue_access(amc_pkg::REQ_WRITE, ctrl_addr(amc_pkg::REG_MODE_FIRST | 5'd1), 8'h00);
    queue_access(amc_pkg::REQ_WRITE, ctrl_addr(amc_pkg::REG_MODE_FIRST), 8'h01);
    queue_access(amc_pkg::REQ_WRITE, ctrl_addr(amc_pkg::REG_OFFSET_LAST), 8'hA5); // bit 6
    queue_access(amc_pkg::REQ_WRITE, ctrl_addr(amc_pkg::REG_OFFSET_FIRST + 5'd2), 8'h5A);
    queue_access(amc_pkg::REQ_WRITE, ctrl_addr(amc_pkg::REG_OFFSET_FIRST | 5'd1), 8'h80);
    queue_access(amc_pkg::REQ_WRITE, ctrl_addr(amc_pkg::REG_RATE_LAST), 8'h7F); // bit 1
    queue_access(amc_pkg::REQ_WRITE, ctrl_addr(amc_pkg::REG_RATE_FIRST | 5'd1), 8'h33);
    queue_access(amc_pkg::REQ_WRITE, ctrl_addr(amc_pkg::REG_PAGE1), 8'h11); // remap = ROM
    queue_access(amc_pkg::REQ_WRITE, ctrl_addr(amc_pkg::REG_RAM_MAP), 8'h22); // all-RAM
    queue_access(amc_pkg::REQ_WRITE, ctrl_addr(amc_pkg::REG_PAGE1), 8'h44); // no remap
    queue_access(amc_pkg::REQ_WRITE, ctrl_addr(amc_pkg::REG_ROM_MAP), 8'h88); // = page
    queue_access(amc_pkg::REQ_WRITE, ctrl_addr(amc_pkg::REG_PAGE0), 8'hC3);
    // memory size locations, then the all-RAM location once more
    queue_access(amc_pkg::REQ_WRITE, ctrl_addr(amc_pkg::REG_RATE_LAST + 5'd1), 8'h5A);
    queue_access(amc_pkg::REQ_WRITE, ctrl_addr(amc_pkg::REG_ROM_MAP - 5'd1), 8'hE7);
    queue_access(amc_pkg::REQ_WRITE, ctrl_addr(amc_pkg::REG_RAM_MAP), 8'h3C);
    queue_access(REQ_READ, amc_pkg::VECTOR_BASE, 8'h00);              // vector fetch
    queue_access(amc_pkg::REQ_WRITE, 16'hFFFF, 8'hFF);
    queue_access(REQ_READ, 16'hFFFE, 8'h96);
    // hole above the controls and addresses below them
    queue_access(amc_pkg::REQ_WRITE, amc_pkg::CTRL_LAST + ADDR_STEP, 8'hFF);
    queue_access(amc_pkg::REQ_WRITE, amc_pkg::VECTOR_BASE - ADDR_STEP, 8'h69);
    queue_access(amc_pkg::REQ_WRITE, 16'h0000, 8'h00);
    queue_access(amc_pkg::REQ_WRITE, amc_pkg::CTRL_BASE - ADDR_STEP, 8'hFF);
    queue_access(REQ_READ, 16'h7FFF, 8'hAA);

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    add_random(300);
    // sender pause: let every outstanding result drain first
    while (pending_q.size() != 0 || result_q.size() != 0) @(posedge clk_i);
    add_random(250);  // the long receiver hold-off falls in here
    while (pending_q.size() != 0) @(posedge clk_i);
    calm = 1'b1;      // closing stretch with no idling
    add_random(250);

    while (pending_q.size() != 0 || result_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb_address_multiplexer_control_regs_unit: done, clean");
    end else begin
      $display("tb_address_multiplexer_control_regs_unit: done, errors");
    end
    $finish;
  end

endmodule

@@ address_multiplexer_control_regs_unit.f @@
sv/amc_pkg.sv
sv/amc_decode.sv
sv/amc_state.sv
sv/address_multiplexer_control_regs_unit.sv
tb/tb_address_multiplexer_control_regs_unit.sv
